>>> hw/rtl/md5_message_digest_unit_assert.svh
// ----------------------------------------------------------------------------
// md5_message_digest_unit_assert
// Assertion macros for the MD5 digest unit.
// ----------------------------------------------------------------------------
`ifndef MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define MD5_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MD5_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("lbl");
`define MD5_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("lbl");
`else
`define MD5_ASSERT_IMPL(lbl, clk, rst, a, c)
`define MD5_ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

>>> hw/rtl/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// Constants, tables and command types shared by the MD5 digest unit.
// ----------------------------------------------------------------------------
package md5_pkg;
   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [31:0] PAD_MARK = 32'h00000080;
   localparam logic [3:0] LEN_POS = 4'd14;

   // word source for buffer writes
   localparam logic [1:0] SRC_DATA = 2'd0;
   localparam logic [1:0] SRC_ZERO = 2'd1;
   localparam logic [1:0] SRC_LENLO = 2'd2;
   localparam logic [1:0] SRC_LENHI = 2'd3;

   typedef struct packed {
      logic       push;       // write one word into the buffer
      logic [1:0] src;
      logic       mark;       // merge 0x80 at byte count
      logic [2:0] nbytes;
      logic [5:0] len_add;    // bits added to length
      logic       add_len;
      logic       round;      // run one round
      logic       round_init; // load working regs from chain
      logic       fold;       // add working regs to chain
      logic       restart;    // back to initial chain, clear length/position
   } md5_cmd_type;

   typedef struct packed {
      logic [3:0] pos;
      logic [5:0] rnd;
   } md5_stat_type;

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] t [64];
      t = '{32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
            32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
            32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
            32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
            32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
            32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
            32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
            32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
            32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
            32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
            32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
      return t[r];
   endfunction

   function automatic logic [4:0] round_s(input logic [5:0] r);
      logic [4:0] s;
      case (r[5:4])
         2'd0: s = (r[1:0] == 2'd0) ? 5'd7 : (r[1:0] == 2'd1) ? 5'd12 :
                   (r[1:0] == 2'd2) ? 5'd17 : 5'd22;
         2'd1: s = (r[1:0] == 2'd0) ? 5'd5 : (r[1:0] == 2'd1) ? 5'd9 :
                   (r[1:0] == 2'd2) ? 5'd14 : 5'd20;
         2'd2: s = (r[1:0] == 2'd0) ? 5'd4 : (r[1:0] == 2'd1) ? 5'd11 :
                   (r[1:0] == 2'd2) ? 5'd16 : 5'd23;
         default: s = (r[1:0] == 2'd0) ? 5'd6 : (r[1:0] == 2'd1) ? 5'd10 :
                   (r[1:0] == 2'd2) ? 5'd15 : 5'd21;
      endcase
      return s;
   endfunction

   // message word index for a round
   function automatic logic [3:0] round_g(input logic [5:0] r);
      logic [3:0] g;
      case (r[5:4])
         2'd0: g = r[3:0];
         2'd1: g = r[3:0] * 4'd5 + 4'd1;
         2'd2: g = r[3:0] * 4'd3 + 4'd5;
         default: g = r[3:0] * 4'd7;
      endcase
      return g;
   endfunction
endpackage

>>> hw/rtl/md5_ram.sv
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hw/rtl/md5_datapath.sv
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, length counter, round registers and chaining words.
// ----------------------------------------------------------------------------
module md5_datapath (
   input  logic                clock,
   input  logic                reset,
   input  md5_pkg::md5_cmd_type cmd,
   input  logic [31:0]         data_word,
   input  logic [1:0]          out_sel,
   output md5_pkg::md5_stat_type stat,
   output logic [31:0]         digest_word
);
   import md5_pkg::*;

   logic [31:0] ca_ff, cb_ff, cc_ff, cd_ff;
   logic [31:0] wa_ff, wb_ff, wc_ff, wd_ff;
   logic [63:0] len_ff, len_in;
   logic [3:0]  pos_ff;
   logic [5:0]  rnd_ff;
   logic [31:0] wr_data, rd_data, mask, f, sum, rot;
   logic [5:0]  rd_r;
   logic [3:0]  rd_addr;

   always_comb begin
      mask = 32'hffffffff;
      case (cmd.nbytes)
         3'd0: mask = 32'h0;
         3'd1: mask = 32'h000000ff;
         3'd2: mask = 32'h0000ffff;
         3'd3: mask = 32'h00ffffff;
         default: mask = 32'hffffffff;
      endcase
      case (cmd.src)
         SRC_DATA: wr_data = data_word & mask;
         SRC_ZERO: wr_data = '0;
         SRC_LENLO: wr_data = len_ff[31:0];
         default: wr_data = len_ff[63:32];
      endcase
      if (cmd.mark) wr_data = wr_data | (PAD_MARK << {cmd.nbytes[1:0], 3'd0});
   end

   assign len_in = len_ff + {58'd0, cmd.len_add};

   // read address runs one round ahead, since read data is registered
   assign rd_r = cmd.round_init ? 6'd0 : rnd_ff + 6'd1;
   assign rd_addr = round_g(rd_r);

   md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
      .clock(clock), .wr_en(cmd.push), .wr_addr(pos_ff), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data));

   always_comb begin
      case (rnd_ff[5:4])
         2'd0: f = (wb_ff & wc_ff) | (~wb_ff & wd_ff);
         2'd1: f = (wd_ff & wb_ff) | (~wd_ff & wc_ff);
         2'd2: f = wb_ff ^ wc_ff ^ wd_ff;
         default: f = wc_ff ^ (wb_ff | ~wd_ff);
      endcase
      sum = wa_ff + f + round_k(rnd_ff) + rd_data;
      rot = (sum << round_s(rnd_ff)) | (sum >> (6'd32 - {1'b0, round_s(rnd_ff)}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= INIT_A; cb_ff <= INIT_B; cc_ff <= INIT_C; cd_ff <= INIT_D;
         wa_ff <= '0; wb_ff <= '0; wc_ff <= '0; wd_ff <= '0;
         len_ff <= '0; pos_ff <= '0; rnd_ff <= '0;
      end else begin
         if (cmd.add_len) len_ff <= len_in;
         if (cmd.push) pos_ff <= pos_ff + 4'd1;
         if (cmd.round_init) begin
            wa_ff <= ca_ff; wb_ff <= cb_ff; wc_ff <= cc_ff; wd_ff <= cd_ff;
            rnd_ff <= '0;
         end else if (cmd.round) begin
            wa_ff <= wd_ff; wd_ff <= wc_ff; wc_ff <= wb_ff; wb_ff <= wb_ff + rot;
            rnd_ff <= rnd_ff + 6'd1;
         end
         if (cmd.fold) begin
            ca_ff <= ca_ff + wa_ff; cb_ff <= cb_ff + wb_ff;
            cc_ff <= cc_ff + wc_ff; cd_ff <= cd_ff + wd_ff;
         end
         if (cmd.restart) begin
            ca_ff <= INIT_A; cb_ff <= INIT_B; cc_ff <= INIT_C; cd_ff <= INIT_D;
            len_ff <= '0; pos_ff <= '0;
         end
      end
   end

   assign stat.pos = pos_ff;
   assign stat.rnd = rnd_ff;

   always_comb begin
      case (out_sel)
         2'd0: digest_word = ca_ff;
         2'd1: digest_word = cb_ff;
         2'd2: digest_word = cc_ff;
         default: digest_word = cd_ff;
      endcase
   end
endmodule

>>> hw/rtl/md5_control.sv
// ----------------------------------------------------------------------------
// md5_control
// Sequencer: word intake, padding, round loop and digest output.
// ----------------------------------------------------------------------------
module md5_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [2:0]           req_bytes,
   input  logic                 req_tlast,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [1:0]           out_sel,
   input  md5_pkg::md5_stat_type stat,
   output md5_pkg::md5_cmd_type cmd
);
   import md5_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_FOLD = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       fin_ff, fin_in;     // in padding phase
   logic       word4_ff, word4_in; // marker word still owed
   logic [1:0] sel_ff, sel_in;
   logic [2:0] nb;
   logic       acc;
   // set when the length words went in during the last padding pass
   logic       pad_done, pad_done_ff;
   // last buffer write was the low length word
   logic       lenlo_ff;

   assign nb = (req_bytes > 3'd4) ? 3'd4 : req_bytes;
   assign req_tready = (state_ff == ST_IDLE);
   assign acc = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign out_sel = sel_ff;
   assign pad_done = pad_done_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      fin_in = fin_ff;
      word4_in = word4_ff;
      sel_in = sel_ff;
      case (state_ff)
         ST_IDLE: if (acc) begin
            cmd.push = 1'b1;
            cmd.src = SRC_DATA;
            cmd.add_len = 1'b1;
            if (!req_tlast) begin
               cmd.nbytes = 3'd4;
               cmd.len_add = 6'd32;
            end else begin
               cmd.nbytes = nb;
               cmd.len_add = {nb, 3'd0};
               cmd.mark = (nb != 3'd4);
               word4_in = (nb == 3'd4);
               fin_in = 1'b1;
            end
            state_in = (stat.pos == 4'd15) ? ST_PREP : (req_tlast ? ST_PAD : ST_IDLE);
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            cmd.src = SRC_ZERO;
            if (word4_ff) begin
               cmd.mark = 1'b1; cmd.nbytes = 3'd0;
               word4_in = 1'b0;
            end else if (stat.pos == LEN_POS) cmd.src = SRC_LENLO;
            // high length word only right after the low one; a marker in
            // word 14 leaves word 15 zero and pushes the length to a new block
            else if (stat.pos == 4'd15 && lenlo_ff) cmd.src = SRC_LENHI;
            state_in = (stat.pos == 4'd15) ? ST_PREP : ST_PAD;
         end
         ST_PREP: begin
            cmd.round_init = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.round = 1'b1;
            if (stat.rnd == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!fin_ff) state_in = ST_IDLE;
            else if (word4_ff || pad_done) state_in = word4_ff ? ST_PAD : ST_OUT;
            else state_in = ST_PAD;
            sel_in = 2'd0;
         end
         ST_OUT: if (rsp_tready) begin
            sel_in = sel_ff + 2'd1;
            if (sel_ff == 2'd3) begin
               cmd.restart = 1'b1;
               fin_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; fin_ff <= 1'b0; word4_ff <= 1'b0; sel_ff <= '0;
         pad_done_ff <= 1'b0; lenlo_ff <= 1'b0;
      end else begin
         state_ff <= state_in; fin_ff <= fin_in; word4_ff <= word4_in; sel_ff <= sel_in;
         if (cmd.push && cmd.src == SRC_LENHI) pad_done_ff <= 1'b1;
         else if (cmd.restart) pad_done_ff <= 1'b0;
         if (cmd.push) lenlo_ff <= (cmd.src == SRC_LENLO);
      end
   end
endmodule

>>> hw/rtl/md5_message_digest_unit.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit
// MD5 digest over a stream of little-endian 32-bit message words.
// ----------------------------------------------------------------------------
// Send message words on req_; the item with tlast ends the message and its
// valid byte count (0..4, above 4 taken as 4) trims it. Words are taken back
// to back, except the sixteenth of a block, which starts the round loop and
// holds off further words: setup, one MD5 round per cycle, then chain update.
// After the last word the unit pads, runs one or two final blocks and returns
// four items A, B, C, D, the fourth with tlast, then starts a fresh message.
// The buffer is a 16-word RAM.
module md5_message_digest_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_word
   input  logic [2:0]  req_tuser,   // valid_bytes
   input  logic        req_tlast,   // last_word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [1:0]  rsp_tuser,   // digest_index
   output logic        rsp_tlast    // digest_last
);
   import md5_pkg::*;
`include "md5_message_digest_unit_assert.svh"

   md5_cmd_type  cmd;
   md5_stat_type stat;
   logic [1:0]   out_sel;

   md5_control u_ctl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_bytes(req_tuser), .req_tlast(req_tlast), .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid), .out_sel(out_sel), .stat(stat), .cmd(cmd));

   md5_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .data_word(req_tdata),
      .out_sel(out_sel), .stat(stat), .digest_word(rsp_tdata));

   assign rsp_tuser = out_sel;
   assign rsp_tlast = (out_sel == 2'd3);

   `MD5_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `MD5_ASSERT_IMPL(a_one_op, clock, reset, cmd.round, !cmd.push)
   `MD5_ASSERT_NEXT(a_restart_pos, clock, reset, cmd.restart, stat.pos == 4'd0)
endmodule

>>> dv/md5_message_digest_unit_tb.sv
// ----------------------------------------------------------------------------
// md5_message_digest_unit_tb
// Self-checking bench for the MD5 digest unit: random and directed messages,
// digest predicted in the bench, results compared item by item.
// ----------------------------------------------------------------------------
module md5_message_digest_unit_tb;
   import md5_pkg::*;

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } word_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  index;
      logic        last;
   } digest_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // data_word
   logic [2:0]  req_tuser = '0;   // valid_bytes
   logic        req_tlast = 1'b0; // last_word
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // digest_word
   logic [1:0]  rsp_tuser;        // digest_index
   logic        rsp_tlast;        // digest_last

   md5_message_digest_unit dut (.*);

   always #2 clock = ~clock;

   // idle modes: 0 sender 9% / receiver 55%, 1 swapped, 2 none
   int          idle_mode = 0;
   bit          rx_hold = 1'b0;   // long receiver hold-off
   bit          req_taken = 1'b0; // input item accepted at the last rising edge
   int          fail_count = 0;
   int          quiet_cycles = 0;
   word_item_type   pending_words[$];
   digest_item_type expected_digests[$];

   // predictor state
   logic [31:0] chain [4];
   logic [31:0] blk [16];
   logic [3:0]  wpos;
   logic [63:0] bitlen;

   function automatic logic [31:0] rol(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void compress();
      logic [31:0] a, b, c, d, f, t;
      int g;
      int sh[16];
      sh = '{7,12,17,22,5,9,14,20,4,11,16,23,6,10,15,21};
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      for (int r = 0; r < 64; r++) begin
         case (r / 16)
            0: begin f = (b & c) | (~b & d); g = r; end
            1: begin f = (d & b) | (~d & c); g = (5 * r + 1) % 16; end
            2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
            default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
         endcase
         // sine constants: |sin(r+1)| * 2^32, taken from the package table
         t = d; d = c; c = b;
         b = b + rol(a + f + round_k(6'(r)) + blk[g], sh[(r / 16) * 4 + r % 4]);
         a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
   endfunction

   function automatic void store_word(input logic [31:0] w);
      blk[wpos] = w;
      wpos++;
      if (wpos == 0) compress();
   endfunction

   function automatic void restart_digest();
      chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
      wpos = 0;
      bitlen = 0;
   endfunction

   // advances the digest state by one accepted word, queues digest items
   function automatic void digest_accept(input word_item_type it);
      int n;
      logic [31:0] mask;
      n = (it.nbytes > 4) ? 4 : it.nbytes;
      if (!it.last) begin
         bitlen += 32;
         store_word(it.data);
         return;
      end
      bitlen += 64'(8 * n);
      if (n == 4) begin
         store_word(it.data);
         store_word(PAD_MARK);
      end else begin
         mask = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
         store_word((it.data & mask) | (PAD_MARK << (8 * n)));
      end
      if (wpos == 15) store_word('0);
      while (wpos != LEN_POS) store_word('0);
      store_word(bitlen[31:0]);
      store_word(bitlen[63:32]);
      for (int k = 0; k < 4; k++)
         expected_digests.push_back('{chain[k], 2'(k), k == 3});
      restart_digest();
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   // driver: new item or idle chosen at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_words.size() > 0 &&
             !(idle_mode == 0 && $urandom_range(99) < 9) &&
             !(idle_mode == 1 && $urandom_range(99) < 55)) begin
            word_item_type it;
            it = pending_words.pop_front();
            req_tdata  <= it.data;
            req_tuser  <= it.nbytes;
            req_tlast  <= it.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rx_hold) rsp_tready <= 1'b0;
      else if (idle_mode == 0) rsp_tready <= ($urandom_range(99) >= 55);
      else if (idle_mode == 1) rsp_tready <= ($urandom_range(99) >= 9);
      else rsp_tready <= 1'b1;
   end

   // monitor: prediction on input acceptance, compare on output acceptance
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (req_tvalid && req_tready)
            digest_accept('{req_tdata, req_tuser, req_tlast});
         if (rsp_tvalid && rsp_tready) begin
            if (expected_digests.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 32'd0);
            end else begin
               digest_item_type e;
               e = expected_digests.pop_front();
               if (rsp_tdata !== e.word) report_mismatch("word", rsp_tdata, e.word);
               if (rsp_tuser !== e.index)
                  report_mismatch("index", 32'(rsp_tuser), 32'(e.index));
               if (rsp_tlast !== e.last)
                  report_mismatch("last", 32'(rsp_tlast), 32'(e.last));
            end
         end
         if (quiet_cycles > 20000) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic void add_word(input logic [31:0] d, input logic [2:0] n,
                                    input logic l);
      pending_words.push_back('{d, n, l});
   endfunction

   // message of len full words then a last word; mostly well formed
   function automatic void add_message(input int len);
      for (int i = 0; i < len; i++)
         add_word($urandom, ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4,
                  1'b0);
      add_word($urandom, 3'($urandom_range(7)), 1'b1);
   endfunction

   task automatic drain();
      while (pending_words.size() > 0 || req_tvalid || expected_digests.size() > 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   initial begin
      restart_digest();
      blk = '{default: '0};
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // directed: empty message, every byte count, one length at the block boundary
      add_word(32'hffffffff, 3'd0, 1'b1);
      for (int n = 1; n <= 7; n++) add_word(32'hffffffff, 3'(n), 1'b1);
      add_word(32'h0, 3'd4, 1'b1);
      for (int i = 0; i < 13; i++) add_word(32'hffffffff, 3'd1, 1'b0); // short, not last
      add_word(32'h0, 3'd3, 1'b1);
      drain();

      // random, three idle modes
      for (int m = 0; m < 3; m++) begin
         idle_mode = m;
         while (pending_words.size() < 140)
            add_message(($urandom_range(5) == 0) ? $urandom_range(40) : $urandom_range(17));
         if (m == 1) begin
            // receiver holds off while the sender keeps offering
            rx_hold = 1'b1;
            repeat (600) @(posedge clock);
            rx_hold = 1'b0;
         end
         drain();
      end

      // length wrap modulo 2^64 is not reachable in a run; wpos edge cases covered
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
